// ===== rtl/ipbw_pkg.sv =====
// Shared types and constants of the indexed pixel banked writer.
// No dependencies; every other file of the block but ipbw_queue refers to this package.
package ipbw_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_PIXEL   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Pixel modes
    localparam logic [1:0] MODE_INDEX  = 2'd0;
    localparam logic [1:0] MODE_RGB565 = 2'd1;
    localparam logic [1:0] MODE_BGR888 = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APERTURE_SHIFT = 3'd4;
    localparam int CFG_DATA_W = 14;

    // Fixed field widths
    localparam int SIZE_W   = 13;
    localparam int SCAN_W   = 14;
    localparam int SHIFT_W  = 5;
    localparam int BANK_W   = 10;
    localparam int OFFSET_W = 22;

    // Aperture shift limits
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd22;

    // Reset values of the configuration registers
    localparam logic [1:0]         RST_PIXEL_MODE     = MODE_INDEX;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [SCAN_W-1:0]  RST_SCANLINE_BYTES = 14'd640;
    localparam logic [SHIFT_W-1:0] RST_APERTURE_SHIFT = 5'd16;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] pixel_index;
        logic [7:0] entry_blue;
        logic [7:0] entry_green;
        logic [7:0] entry_red;
    } t_in;

    typedef struct packed {
        logic [BANK_W-1:0]   bank_number;
        logic [OFFSET_W-1:0] aperture_offset;
        logic [15:0]         write_data;
        logic [1:0]          byte_count;
        logic                bank_changed;
        logic                pixel_end;
        logic                frame_end;
    } t_out;

    typedef struct packed {
        logic [1:0]         pixel_mode;
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [SCAN_W-1:0]  scanline_bytes;
        logic [SHIFT_W-1:0] aperture_shift;
    } t_cfg;

    // Classified pixel job handed from front to back (address travels beside it)
    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] colour;       // red 23:16, green 15:8, blue 7:0
        logic [7:0]  pixel_index;
        logic        frame_last;
    } t_job;

    // Pack a palette colour as RGB565
    function automatic logic [15:0] to_rgb565(input logic [23:0] colour);
        return {colour[23:19], colour[15:10], colour[7:3]};
    endfunction

endpackage

// ===== rtl/ipbw_front.sv =====
// Front end: accepts input transactions, holds the palette and raster position,
// and turns each pixel into a job with its start address. Uses ipbw_pkg.
module ipbw_front #(
    parameter int PALETTE_DEPTH = 256,
    parameter int COORD_BITS    = 12,
    parameter int ADDRESS_BITS  = 26
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ipbw_pkg::t_in           i_in_data,
    input  ipbw_pkg::t_cfg          i_cfg,
    output logic                    o_job_valid,
    output ipbw_pkg::t_job          o_job,
    output logic [ADDRESS_BITS-1:0] o_job_addr,
    input  logic                    i_job_ready
);

    localparam int SLOT_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CMP_W  = ((COORD_BITS > ipbw_pkg::SIZE_W) ? COORD_BITS
                                                             : ipbw_pkg::SIZE_W) + 1;
    localparam logic [CMP_W-1:0] SIZE_TOP = CMP_W'(1) << COORD_BITS;

    logic                    accept;
    logic                    is_pixel;
    logic                    is_load;
    logic                    is_restart;
    logic [11:0]             slot_rem;
    logic [SLOT_W-1:0]       slot;
    logic [CMP_W-1:0]        w_eff;
    logic [CMP_W-1:0]        h_eff;
    logic                    row_last;
    logic                    frame_last;
    logic [ADDRESS_BITS-1:0] col_x;
    logic [ADDRESS_BITS-1:0] col_off;
    logic [ADDRESS_BITS-1:0] pix_addr;

    logic [23:0]             r_pal_mem [PALETTE_DEPTH];
    logic [23:0]             r_pal_rd;
    logic                    r_s1_valid, n_s1_valid;
    logic [1:0]              r_s1_mode;
    logic [7:0]              r_s1_idx;
    logic                    r_s1_frame_last;
    logic [ADDRESS_BITS-1:0] r_s1_addr;
    logic [COORD_BITS-1:0]   r_col, n_col;
    logic [COORD_BITS-1:0]   r_row, n_row;
    logic [ADDRESS_BITS-1:0] r_row_base, n_row_base;

    // Handshake: take a new transaction whenever the stage register is free or moving
    assign o_in_ready = !r_s1_valid || i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pixel   = (i_in_data.operation == ipbw_pkg::OP_PIXEL);
    assign is_load    = (i_in_data.operation == ipbw_pkg::OP_LOAD);
    assign is_restart = (i_in_data.operation == ipbw_pkg::OP_RESTART);

    // Palette slot: index reduced modulo the depth by restoring subtraction
    always_comb begin
        slot_rem = {4'd0, i_in_data.pixel_index};
        for (int k = 3; k >= 0; k--) begin
            if (slot_rem >= 12'(PALETTE_DEPTH << k)) begin
                slot_rem = slot_rem - 12'(PALETTE_DEPTH << k);
            end
        end
        slot = slot_rem[SLOT_W-1:0];
    end

    // Effective frame size, clamped to 1..2^COORD_BITS
    always_comb begin
        w_eff = CMP_W'(i_cfg.image_width);
        if (i_cfg.image_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_eff > SIZE_TOP) begin
            w_eff = SIZE_TOP;
        end
        h_eff = CMP_W'(i_cfg.image_height);
        if (i_cfg.image_height == '0) begin
            h_eff = CMP_W'(1);
        end else if (h_eff > SIZE_TOP) begin
            h_eff = SIZE_TOP;
        end
    end

    assign row_last   = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
    assign frame_last = row_last && ((CMP_W'(r_row) + CMP_W'(1)) >= h_eff);

    // Pixel start address: row base plus column times pixel bytes
    assign col_x = ADDRESS_BITS'(r_col);
    always_comb begin
        case (i_cfg.pixel_mode)
            ipbw_pkg::MODE_RGB565: col_off = col_x << 1;
            ipbw_pkg::MODE_BGR888: col_off = col_x + (col_x << 1);
            default:               col_off = col_x;
        endcase
    end
    assign pix_addr = r_row_base + col_off;

    // Raster position update
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_row_base = r_row_base;
        if (accept && is_restart) begin
            n_col      = '0;
            n_row      = '0;
            n_row_base = '0;
        end else if (accept && is_pixel) begin
            if (row_last) begin
                n_col = '0;
                if (frame_last) begin
                    n_row      = '0;
                    n_row_base = '0;
                end else begin
                    n_row      = r_row + COORD_BITS'(1);
                    n_row_base = r_row_base + ADDRESS_BITS'(i_cfg.scanline_bytes);
                end
            end else begin
                n_col = r_col + COORD_BITS'(1);
            end
        end
    end

    // Stage register occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept && is_pixel) begin
            n_s1_valid = 1'b1;
        end else if (i_job_ready) begin
            n_s1_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept && is_pixel) begin
            r_s1_mode       <= i_cfg.pixel_mode;
            r_s1_idx        <= i_in_data.pixel_index;
            r_s1_frame_last <= frame_last;
            r_s1_addr       <= pix_addr;
        end
    end

    // Palette memory write port
    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_pal_mem[slot] <= {i_in_data.entry_red, i_in_data.entry_green,
                                i_in_data.entry_blue};
        end
    end

    // Palette memory registered read port
    always_ff @(posedge i_clk) begin
        if (accept && is_pixel) begin
            r_pal_rd <= r_pal_mem[slot];
        end
    end

    assign o_job_valid      = r_s1_valid;
    assign o_job.mode       = r_s1_mode;
    assign o_job.colour     = r_pal_rd;
    assign o_job.pixel_index = r_s1_idx;
    assign o_job.frame_last = r_s1_frame_last;
    assign o_job_addr       = r_s1_addr;

endmodule

// ===== rtl/ipbw_queue.sv =====
// Small job queue between front and back ends.
// Register array with read and write pointers; no package dependency.
module ipbw_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_pop_valid,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_entry[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/ipbw_back.sv =====
// Back end: expands each queued pixel job into one or three frame-buffer
// writes with bank, offset and flags, into an output register. Uses ipbw_pkg.
module ipbw_back #(
    parameter int ADDRESS_BITS = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ipbw_pkg::SHIFT_W-1:0]  i_aperture_shift,
    input  logic                          i_job_valid,
    input  ipbw_pkg::t_job                i_job,
    input  logic [ADDRESS_BITS-1:0]       i_job_addr,
    output logic                          o_job_pop,
    output logic                          o_out_valid,
    output ipbw_pkg::t_out                o_out_data,
    input  logic                          i_out_ready
);

    localparam int XW = (ADDRESS_BITS > ipbw_pkg::OFFSET_W) ? ADDRESS_BITS
                                                            : ipbw_pkg::OFFSET_W;

    logic [ipbw_pkg::SHIFT_W-1:0]  sh;
    logic [ipbw_pkg::OFFSET_W-1:0] off_mask;
    logic [ADDRESS_BITS-1:0]       beat_addr;
    logic [XW-1:0]                 addr_x;
    logic [XW-1:0]                 addr_sh;
    logic [ipbw_pkg::BANK_W-1:0]   bank;
    logic                          out_free;
    logic                          emit;
    logic                          last_beat;
    logic [15:0]                   wdata;
    ipbw_pkg::t_out                beat_out;

    logic [1:0]                    r_beat, n_beat;
    logic                          r_out_valid;
    ipbw_pkg::t_out                r_out;
    logic [ipbw_pkg::BANK_W-1:0]   r_cur_bank;

    // Output register frees when empty or being taken
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit      = i_job_valid && out_free;
    assign last_beat = (i_job.mode == ipbw_pkg::MODE_BGR888) ? (r_beat == 2'd2) : 1'b1;
    assign o_job_pop = emit && last_beat;

    // Clamp the aperture shift
    always_comb begin
        sh = i_aperture_shift;
        if (i_aperture_shift < ipbw_pkg::SHIFT_MIN) begin
            sh = ipbw_pkg::SHIFT_MIN;
        end else if (i_aperture_shift > ipbw_pkg::SHIFT_MAX) begin
            sh = ipbw_pkg::SHIFT_MAX;
        end
    end

    // Bank and offset of this byte or word
    assign beat_addr = i_job_addr + ADDRESS_BITS'(r_beat);
    assign addr_x    = XW'(beat_addr);
    assign addr_sh   = addr_x >> sh;
    assign bank      = addr_sh[ipbw_pkg::BANK_W-1:0];
    assign off_mask  = {ipbw_pkg::OFFSET_W{1'b1}} >> (ipbw_pkg::SHIFT_MAX - sh);

    // Write data per mode and beat
    always_comb begin
        case (i_job.mode)
            ipbw_pkg::MODE_RGB565: wdata = ipbw_pkg::to_rgb565(i_job.colour);
            ipbw_pkg::MODE_BGR888: begin
                case (r_beat)
                    2'd0:    wdata = {8'd0, i_job.colour[7:0]};
                    2'd1:    wdata = {8'd0, i_job.colour[15:8]};
                    default: wdata = {8'd0, i_job.colour[23:16]};
                endcase
            end
            default:               wdata = {8'd0, i_job.pixel_index};
        endcase
    end

    always_comb begin
        beat_out.bank_number     = bank;
        beat_out.aperture_offset = addr_x[ipbw_pkg::OFFSET_W-1:0] & off_mask;
        beat_out.write_data      = wdata;
        beat_out.byte_count      = (i_job.mode == ipbw_pkg::MODE_RGB565) ? 2'd2 : 2'd1;
        beat_out.bank_changed    = (bank != r_cur_bank);
        beat_out.pixel_end       = last_beat;
        beat_out.frame_end       = last_beat && i_job.frame_last;
    end

    // Beat counter within a pixel
    always_comb begin
        n_beat = r_beat;
        if (emit) begin
            n_beat = last_beat ? 2'd0 : r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= 2'd0;
            r_out_valid <= 1'b0;
            r_cur_bank  <= '0;
        end else begin
            r_beat <= n_beat;
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_cur_bank <= bank;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= beat_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/indexed_pixel_banked_writer_top.sv =====
// Top level of the indexed pixel banked writer: configuration registers,
// front end, job queue and back end. Uses ipbw_pkg, ipbw_front, ipbw_queue, ipbw_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries pixel, palette
//   load and restart transactions. Pixels arrive in raster order.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one or three
//   frame-buffer writes per pixel transaction: bank, offset, data and flags.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index;
//   write only while the block is idle.
// Path: a pixel passes from the front stage register into the queue and then into
//   the back end's output register, from which its first write is offered.
// Throughput: one write per cycle from the back end's output register while
//   i_out_ready is high, so one pixel per cycle in index and RGB565 modes; in BGR
//   mode the back end emits three byte writes per pixel. Loads and restarts
//   produce no write.
// Reset: position, bank tracking and queue clear; registers return to their
//   defaults. Palette contents are undefined until loaded.
// Stall: while i_out_ready is low the output register holds, the queue fills,
//   and o_in_ready drops once the queue and the front stage are full.
module indexed_pixel_banked_writer_top #(
    parameter int PALETTE_DEPTH = 256,
    parameter int COORD_BITS    = 12,
    parameter int ADDRESS_BITS  = 26,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ipbw_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ipbw_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [ipbw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ipbw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int JOB_W = $bits(ipbw_pkg::t_job);
    localparam int QW    = JOB_W + ADDRESS_BITS;

    ipbw_pkg::t_cfg          r_cfg;
    logic                    front_job_valid;
    ipbw_pkg::t_job          front_job;
    logic [ADDRESS_BITS-1:0] front_job_addr;
    logic                    q_push_ready;
    logic                    q_pop;
    logic                    q_valid;
    logic [QW-1:0]           q_data;
    ipbw_pkg::t_job          back_job;
    logic [ADDRESS_BITS-1:0] back_job_addr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mode     <= ipbw_pkg::RST_PIXEL_MODE;
            r_cfg.image_width    <= ipbw_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height   <= ipbw_pkg::RST_IMAGE_HEIGHT;
            r_cfg.scanline_bytes <= ipbw_pkg::RST_SCANLINE_BYTES;
            r_cfg.aperture_shift <= ipbw_pkg::RST_APERTURE_SHIFT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ipbw_pkg::CFG_PIXEL_MODE:
                    r_cfg.pixel_mode <= i_cfg_wdata[1:0];
                ipbw_pkg::CFG_IMAGE_WIDTH:
                    r_cfg.image_width <= i_cfg_wdata[ipbw_pkg::SIZE_W-1:0];
                ipbw_pkg::CFG_IMAGE_HEIGHT:
                    r_cfg.image_height <= i_cfg_wdata[ipbw_pkg::SIZE_W-1:0];
                ipbw_pkg::CFG_SCANLINE_BYTES:
                    r_cfg.scanline_bytes <= i_cfg_wdata[ipbw_pkg::SCAN_W-1:0];
                ipbw_pkg::CFG_APERTURE_SHIFT:
                    r_cfg.aperture_shift <= i_cfg_wdata[ipbw_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: accept and classify
    ipbw_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .COORD_BITS    (COORD_BITS),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .o_job_valid (front_job_valid),
        .o_job       (front_job),
        .o_job_addr  (front_job_addr),
        .i_job_ready (q_push_ready)
    );

    // Job queue
    ipbw_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_job_valid),
        .i_push_data  ({front_job_addr, front_job}),
        .o_push_ready (q_push_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data)
    );

    assign back_job      = q_data[JOB_W-1:0];
    assign back_job_addr = q_data[QW-1:JOB_W];

    // Back end: write generation
    ipbw_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_aperture_shift (r_cfg.aperture_shift),
        .i_job_valid      (q_valid),
        .i_job            (back_job),
        .i_job_addr       (back_job_addr),
        .o_job_pop        (q_pop),
        .o_out_valid      (o_out_valid),
        .o_out_data       (o_out_data),
        .i_out_ready      (i_out_ready)
    );

endmodule
